@@ src/kmrb_pkg.sv @@
`timescale 1ns / 1ps

package kmrb_pkg;

  // default geometry
  localparam int ROWS_DEF      = 5;
  localparam int COLS_DEF      = 8;
  localparam int KEY_SLOTS_DEF = 6;

  // fixed field widths of the stream words
  localparam int KEY_BITS_W  = 40;
  localparam int INDEX_W     = 6;
  localparam int CODE_W      = 32;
  localparam int USAGE_W     = 8;
  localparam int OUT_SLOTS   = 6;
  localparam int COUNT_W     = 3;
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 64;

  // kind of input word, carried in tuser
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic [USAGE_W-1:0] LEFT_ARROW = 8'h50;
  localparam logic [4:0]         MOD_USAGE_HI = 5'b11100;   // usages 0xE0..0xE7
  localparam logic [CODE_W-1:0]  CODE_1B_MAX = 32'h0000_00FF;
  localparam logic [CODE_W-1:0]  CODE_2B_MAX = 32'h0000_FFFF;
  localparam logic [CODE_W-1:0]  CODE_3B_MAX = 32'h00FF_FFFF;
  localparam int                 WIDE_CODE_MAX_COUNT = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } kmrb_state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic commit;
  } kmrb_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } kmrb_status_t;

endpackage

@@ src/kmrb_ctrl.sv @@
`timescale 1ns / 1ps

module kmrb_ctrl
  import kmrb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_kind,
  output logic         in_ready,
  input  kmrb_status_t status,
  output kmrb_cmd_t    cmd
);

  kmrb_state_t state;
  kmrb_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_kind == CMD_SCAN) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid && in_kind == CMD_LOAD;
        cmd.start = in_valid && in_kind == CMD_SCAN;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/kmrb_datapath.sv @@
`timescale 1ns / 1ps

module kmrb_datapath
  import kmrb_pkg::*;
#(
  parameter int ROWS      = ROWS_DEF,
  parameter int COLS      = COLS_DEF,
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  kmrb_cmd_t             cmd,
  output kmrb_status_t          status,
  input  logic [KEY_BITS_W-1:0] key_bits,
  input  logic [INDEX_W-1:0]    entry_index,
  input  logic [CODE_W-1:0]     entry_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int Depth = ROWS * COLS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SlotW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CntW  = $clog2(KEY_SLOTS + 1);

  // layout table
  logic [CODE_W-1:0] mem [Depth];
  logic [CODE_W-1:0] rd_data;

  logic [AddrW+INDEX_W-1:0] wr_index_ext;
  logic                     wr_in_range;

  assign wr_index_ext = (AddrW + INDEX_W)'(entry_index);
  assign wr_in_range  = 32'(entry_index) < 32'(Depth);

  logic [AddrW-1:0]      pos;
  logic [KEY_BITS_W-1:0] kb;
  logic                  fn;
  logic                  rd_valid;
  logic                  rd_pressed;

  always_ff @(posedge clk) begin
    if (cmd.load && wr_in_range) begin
      mem[wr_index_ext[AddrW-1:0]] <= entry_value;
    end
    if (cmd.step) begin
      rd_data <= mem[pos];
    end
  end

  // walk positions in row-major order; switches beyond key_bits shift in as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kb  <= key_bits;
      fn  <= key_bits[0];
      pos <= '0;
    end else if (cmd.step) begin
      kb         <= kb >> 1;
      rd_pressed <= kb[0];
      pos        <= pos + AddrW'(1);
    end
  end

  assign status.scan_last = (32'(pos) == 32'(Depth - 1));

  // report under construction
  logic [USAGE_W-1:0] keys      [KEY_SLOTS];
  logic [USAGE_W-1:0] keys_next [KEY_SLOTS];
  logic [CntW-1:0]    cnt;
  logic [CntW-1:0]    cnt_next;
  logic [USAGE_W-1:0] mods;
  logic [USAGE_W-1:0] mods_next;

  logic [USAGE_W-1:0] use_byte [3];
  logic [1:0]         use_num;

  always_comb begin
    keys_next = keys;
    cnt_next  = cnt;
    mods_next = mods;
    use_num   = 2'd0;
    use_byte[0] = rd_data[7:0];
    use_byte[1] = rd_data[7:0];
    use_byte[2] = LEFT_ARROW;
    if (rd_valid && rd_pressed && 32'(cnt) < 32'(KEY_SLOTS)) begin
      priority if (rd_data <= CODE_1B_MAX) begin
        use_num = 2'd1;
      end else if (rd_data <= CODE_2B_MAX) begin
        use_num     = 2'd2;
        use_byte[0] = rd_data[15:8];
      end else if (rd_data <= CODE_3B_MAX) begin
        use_num = 2'd0;
      end else if (32'(cnt) <= 32'(WIDE_CODE_MAX_COUNT)) begin
        use_num = 2'd3;
        if (fn) begin
          use_byte[0] = rd_data[15:8];
          use_byte[1] = rd_data[7:0];
        end else begin
          use_byte[0] = rd_data[31:24];
          use_byte[1] = rd_data[23:16];
        end
      end else begin
        use_num = 2'd0;
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (i < int'(use_num)) begin
        if (use_byte[i][7:3] == MOD_USAGE_HI) begin
          mods_next[use_byte[i][2:0]] = 1'b1;
        end else if (32'(cnt_next) < 32'(KEY_SLOTS)) begin
          keys_next[cnt_next[SlotW-1:0]] = use_byte[i];
          cnt_next = cnt_next + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        keys[i] <= '0;
      end
      cnt  <= '0;
      mods <= '0;
    end else begin
      keys <= keys_next;
      cnt  <= cnt_next;
      mods <= mods_next;
    end
  end

  // change test against the previous scan
  logic [USAGE_W-1:0] prev_keys [KEY_SLOTS];
  logic [CntW-1:0]    prev_cnt;
  logic [USAGE_W-1:0] prev_mods;
  logic               changed;

  always_comb begin
    changed = (cnt != prev_cnt) || (mods != prev_mods);
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (32'(i) < 32'(cnt) && keys[i] != prev_keys[i]) changed = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        prev_keys[i] <= '0;
      end
      prev_cnt  <= '0;
      prev_mods <= '0;
    end else if (cmd.commit) begin
      prev_keys <= keys;
      prev_cnt  <= cnt;
      prev_mods <= mods;
    end
  end

  // report word: modifier, six slots, count
  logic [USAGE_W-1:0]     rep_slot [OUT_SLOTS];
  logic [CntW+COUNT_W-1:0] cnt_ext;

  for (genvar g = 0; g < OUT_SLOTS; g++) begin : g_slot
    if (g < KEY_SLOTS) begin : g_used
      assign rep_slot[g] = keys[g];
    end else begin : g_zero
      assign rep_slot[g] = '0;
    end
  end

  assign cnt_ext = (CntW + COUNT_W)'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && changed) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && changed) begin
      out_data <= {5'd0, cnt_ext[COUNT_W-1:0], rep_slot[5], rep_slot[4], rep_slot[3],
                   rep_slot[2], rep_slot[1], rep_slot[0], mods};
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

@@ src/key_matrix_report_builder_top.sv @@
`timescale 1ns / 1ps
// scan word: the controller walks the layout table one entry a cycle, then drains and commits;
// m_axis_tvalid is registered from the commit, and no new word is accepted before it;
// a report word held back by m_axis_tready stalls the commit, and with it the next word
// load word: one per cycle in IDLE, no output; a scan equal to the last one gives no report word
// rst (synchronous) clears the controller, the output stage and the previous report;
// the layout table keeps its contents and must be loaded before use

module key_matrix_report_builder_top
  import kmrb_pkg::*;
#(
  parameter int ROWS      = ROWS_DEF,
  parameter int COLS      = COLS_DEF,
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // key_bits, entry_index, entry_value, zero pad
  input  logic                  s_axis_tuser,  // cmd
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // modifier, key_0..key_5, key_count, zero pad
);

  kmrb_cmd_t    cmd;
  kmrb_status_t status;

  kmrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  kmrb_datapath #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .KEY_SLOTS (KEY_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .key_bits    (s_axis_tdata[KEY_BITS_W-1:0]),
    .entry_index (s_axis_tdata[KEY_BITS_W+INDEX_W-1:KEY_BITS_W]),
    .entry_value (s_axis_tdata[KEY_BITS_W+INDEX_W+CODE_W-1:KEY_BITS_W+INDEX_W]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata)
  );

endmodule
